// File: rtl/core/sccb_pkg.sv
// ----------------------------------------------------------------------------
// SCCB register access master package
// Item types, phase codes, bus level tables and configuration indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package sccb_pkg;

    // Input item: one clock tick of the bus sequencer
    typedef struct packed {
        logic       start_request;
        logic       opcode;
        logic [7:0] reg_address;
        logic [7:0] write_data;
        logic       sda_sample;
    } in_item_t;

    // Result item: bus levels and status for the same tick
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic       success;
        logic [7:0] read_data;
    } out_item_t;

    typedef logic [5:0] phase_t;

    // Configuration port
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PHASE_TICKS    = 1'b1;

    localparam logic [6:0]  DEVICE_ADDRESS_RESET = 7'd33;
    localparam logic [15:0] PHASE_TICKS_RESET    = 16'd250;

    localparam logic OPCODE_WRITE = 1'b0;
    localparam logic OPCODE_READ  = 1'b1;

    // Sequence phases; unnamed codes sit between these and step by one
    localparam phase_t PH_IDLE  = 6'd0;
    localparam phase_t PH_ST0   = 6'd1;
    localparam phase_t PH_ST3   = 6'd4;
    localparam phase_t PH_WB0   = 6'd5;
    localparam phase_t PH_WB2   = 6'd7;
    localparam phase_t PH_AK0   = 6'd8;
    localparam phase_t PH_AK4   = 6'd12;
    localparam phase_t PH_AK5   = 6'd13;
    localparam phase_t PH_AKF   = 6'd14;
    localparam phase_t PH_GAP   = 6'd15;
    localparam phase_t PH_SP0   = 6'd16;
    localparam phase_t PH_SP2   = 6'd18;
    localparam phase_t PH_FS0   = 6'd19;
    localparam phase_t PH_FS2   = 6'd21;
    localparam phase_t PH_WT0   = 6'd22;
    localparam phase_t PH_WT2   = 6'd24;
    localparam phase_t PH_RB0   = 6'd25;
    localparam phase_t PH_RB3   = 6'd28;
    localparam phase_t PH_NA0   = 6'd29;
    localparam phase_t PH_NA4   = 6'd33;
    localparam phase_t PH_COUNT = 6'd34;

    // Bus levels per phase, bit n belongs to phase n
    localparam logic [33:0] SCL_TABLE = 34'b00_1001_1101_1111_0110_0001_1100_0100_1111;
    localparam logic [33:0] SDA_TABLE = 34'b01_1111_1111_1110_0100_1111_1111_0000_0111;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    localparam logic [2:0] BYTE_DEVICE   = 3'd0;
    localparam logic [2:0] BYTE_REGISTER = 3'd1;
    localparam logic [2:0] BYTE_PAYLOAD  = 3'd2;
    localparam logic [2:0] BYTE_READING  = 3'd3;

endpackage : sccb_pkg

`default_nettype wire

// File: rtl/core/sccb_register_access_master.sv
// ----------------------------------------------------------------------------
// SCCB register access master
// Results: one result item per input item, registered and valid in the cycle after accept.
// Throughput: one input item per cycle while the result register is empty or out_ready
// is high; the phase sequencer and its tick counter advance once per accepted item.
// Reset: sequencer idle, counters clear, device address 33, phase length 250;
// the result register is empty after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sccb_register_access_master
    import sccb_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,

    input  wire logic                       in_valid,
    output      logic                       in_ready,
    input  wire in_item_t                   in_data,

    output      logic                       out_valid,
    input  wire logic                       out_ready,
    output      out_item_t                  out_data,

    input  wire logic                       cfg_valid,
    output      logic                       cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    // Configuration registers
    logic [6:0]  device_address_reg;
    logic [15:0] phase_ticks_reg;

    // Sequencer state
    phase_t      phase_reg,    phase_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [2:0]  byte_index_reg, byte_index_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic        req_opcode_reg, req_opcode_next;
    logic [7:0]  req_reg_addr_reg, req_reg_addr_next;
    logic [7:0]  req_wdata_reg, req_wdata_next;

    // Result register
    logic        res_valid_reg;
    out_item_t   res_item_reg;
    out_item_t   res_item_next;

    logic        in_accept;
    logic [16:0] tick_plus;
    logic [16:0] phase_len;
    logic        phase_end;
    logic        is_read;
    logic [7:0]  addr_byte;

    assign cfg_ready = 1'b1;
    assign in_ready  = !res_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;
    assign out_valid = res_valid_reg;
    assign out_data  = res_item_reg;

    // Phase timing, zero length acts as one tick
    assign tick_plus = {1'b0, tick_count_reg} + 17'd1;
    assign phase_len = (phase_ticks_reg == 16'd0) ? 17'd1 : {1'b0, phase_ticks_reg};
    assign phase_end = tick_plus >= phase_len;
    assign is_read   = req_opcode_reg == OPCODE_READ;
    assign addr_byte = {device_address_reg, 1'b0};

    // Sequencer next state and result for one tick
    always_comb
    begin
        logic [2:0] load_index;
        logic       load_now;

        phase_next        = phase_reg;
        bit_count_next    = bit_count_reg;
        byte_index_next   = byte_index_reg;
        shift_byte_next   = shift_byte_reg;
        tick_count_next   = tick_count_reg;
        req_opcode_next   = req_opcode_reg;
        req_reg_addr_next = req_reg_addr_reg;
        req_wdata_next    = req_wdata_reg;
        load_index        = byte_index_reg;
        load_now          = 1'b0;

        res_item_next = '{scl_level: 1'b1, sda_level: 1'b1, busy_res: 1'b0,
                          done_res: 1'b0, success: 1'b0, read_data: 8'd0};

        if (phase_reg == PH_IDLE || phase_reg >= PH_COUNT)
        begin
            phase_next = PH_IDLE;
            if (in_data.start_request)
            begin
                req_opcode_next   = in_data.opcode;
                req_reg_addr_next = in_data.reg_address;
                req_wdata_next    = in_data.write_data;
                byte_index_next   = BYTE_DEVICE;
                bit_count_next    = 4'd0;
                shift_byte_next   = 8'd0;
                tick_count_next   = 16'd0;
                phase_next        = PH_ST0;
            end
        end
        else
        begin
            res_item_next.busy_res  = 1'b1;
            res_item_next.scl_level = SCL_TABLE[phase_reg];
            if (phase_reg >= PH_WB0 && phase_reg <= PH_WB2)
            begin
                res_item_next.sda_level = shift_byte_reg[7];
            end
            else
            begin
                res_item_next.sda_level = SDA_TABLE[phase_reg];
            end

            if (!phase_end)
            begin
                tick_count_next = tick_count_reg + 16'd1;
            end
            else
            begin
                tick_count_next = 16'd0;
                case (phase_reg)
                    PH_ST3:
                    begin
                        load_now = 1'b1;
                    end
                    PH_WB2:
                    begin
                        shift_byte_next = {shift_byte_reg[6:0], 1'b0};
                        bit_count_next  = bit_count_reg + 4'd1;
                        phase_next = (bit_count_next >= BITS_PER_BYTE) ? PH_AK0 : PH_WB0;
                    end
                    PH_AK4:
                    begin
                        // line high here means no acknowledge
                        phase_next = in_data.sda_sample ? PH_AKF : PH_AK5;
                    end
                    PH_AK5:
                    begin
                        phase_next = (!is_read && byte_index_reg >= BYTE_PAYLOAD)
                                     ? PH_SP0 : PH_GAP;
                    end
                    PH_AKF:
                    begin
                        phase_next = PH_FS0;
                    end
                    PH_GAP:
                    begin
                        if (is_read && byte_index_reg == BYTE_REGISTER)
                        begin
                            phase_next = PH_SP0;
                        end
                        else if (is_read && byte_index_reg >= BYTE_PAYLOAD)
                        begin
                            byte_index_next = BYTE_READING;
                            shift_byte_next = 8'd0;
                            bit_count_next  = 4'd0;
                            phase_next      = PH_RB0;
                        end
                        else
                        begin
                            byte_index_next = byte_index_reg + 3'd1;
                            load_index      = byte_index_next;
                            load_now        = 1'b1;
                        end
                    end
                    PH_SP2:
                    begin
                        if (is_read && byte_index_reg == BYTE_REGISTER)
                        begin
                            phase_next = PH_WT0;
                        end
                        else
                        begin
                            phase_next              = PH_IDLE;
                            res_item_next.done_res  = 1'b1;
                            res_item_next.success   = 1'b1;
                            res_item_next.read_data = is_read ? shift_byte_reg : 8'd0;
                        end
                    end
                    PH_FS2:
                    begin
                        phase_next             = PH_IDLE;
                        res_item_next.done_res = 1'b1;
                    end
                    PH_WT2:
                    begin
                        byte_index_next = BYTE_PAYLOAD;
                        phase_next      = PH_ST0;
                    end
                    PH_RB3:
                    begin
                        shift_byte_next = {shift_byte_reg[6:0], in_data.sda_sample};
                        bit_count_next  = bit_count_reg + 4'd1;
                        phase_next = (bit_count_next >= BITS_PER_BYTE) ? PH_NA0 : PH_RB0;
                    end
                    PH_NA4:
                    begin
                        phase_next = PH_SP0;
                    end
                    default:
                    begin
                        phase_next = phase_reg + 6'd1;
                    end
                endcase

                // Load the next byte to send
                if (load_now)
                begin
                    case (load_index)
                        BYTE_DEVICE:   shift_byte_next = addr_byte;
                        BYTE_REGISTER: shift_byte_next = req_reg_addr_reg;
                        default:
                        begin
                            shift_byte_next = is_read ? (addr_byte | 8'd1) : req_wdata_reg;
                        end
                    endcase
                    bit_count_next = 4'd0;
                    phase_next     = PH_WB0;
                end
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= DEVICE_ADDRESS_RESET;
            phase_ticks_reg    <= PHASE_TICKS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEVICE_ADDRESS: device_address_reg <= cfg_data[6:0];
                CFG_PHASE_TICKS:    phase_ticks_reg    <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Sequencer state, advances once per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            bit_count_reg    <= 4'd0;
            byte_index_reg   <= 3'd0;
            shift_byte_reg   <= 8'd0;
            tick_count_reg   <= 16'd0;
            req_opcode_reg   <= 1'b0;
            req_reg_addr_reg <= 8'd0;
            req_wdata_reg    <= 8'd0;
        end
        else if (in_accept)
        begin
            phase_reg        <= phase_next;
            bit_count_reg    <= bit_count_next;
            byte_index_reg   <= byte_index_next;
            shift_byte_reg   <= shift_byte_next;
            tick_count_reg   <= tick_count_next;
            req_opcode_reg   <= req_opcode_next;
            req_reg_addr_reg <= req_reg_addr_next;
            req_wdata_reg    <= req_wdata_next;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            res_item_reg <= res_item_next;
        end
    end

endmodule : sccb_register_access_master

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// SCCB register access master testbench
// Feeds the bus sequencer one tick per item and checks every returned pin
// state against an internal model of the phase sequencer. Directed transfers
// cover the field extremes, every acknowledge failure point, zero and maximum
// phase lengths and a length change inside a phase. Random transfers then run
// with bursty idling on both channels, a long result hold-off and a drain.
// ----------------------------------------------------------------------------

module testbench;
    import sccb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int RANDOM_TICKS   = 200;
    localparam int CALM_TICKS     = 60;
    localparam int REPORT_LIMIT   = 10;
    localparam int IN_BITS        = $bits(in_item_t);

    // Bus levels per phase, bit n belongs to phase n
    localparam bit [33:0] CLK_LEVELS  = 34'b00_1001_1101_1111_0110_0001_1100_0100_1111;
    localparam bit [33:0] DATA_LEVELS = 34'b01_1111_1111_1110_0100_1111_1111_0000_0111;

    typedef enum logic [1:0] {SEQ_RUNNING, SEQ_DONE_OK, SEQ_DONE_FAIL} seq_end_t;

    // Pin-state model of the sequencer plus the store of expected pin states
    class sccb_pin_scoreboard;
        logic [6:0]  dev_addr;
        logic [15:0] phase_len;
        phase_t      phase;
        logic [3:0]  bit_cnt;
        logic [2:0]  byte_idx;
        logic [7:0]  shift_reg;
        logic [15:0] tick_cnt;
        logic        req_read;
        logic [7:0]  req_reg;
        logic [7:0]  req_data;
        out_item_t   expected_pins[$];
        int          failures;

        function void clear();
            dev_addr  = 7'd33;
            phase_len = 16'd250;
            phase     = PH_IDLE;
            bit_cnt   = 4'd0;
            byte_idx  = BYTE_DEVICE;
            shift_reg = 8'd0;
            tick_cnt  = 16'd0;
            req_read  = 1'b0;
            req_reg   = 8'd0;
            req_data  = 8'd0;
            expected_pins.delete();
            failures  = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_WIDTH-1:0] idx, logic [15:0] val);
            if (idx == CFG_DEVICE_ADDRESS)
                dev_addr = val[6:0];
            else
                phase_len = val;
        endfunction

        // Next byte to shift out: device+W, register, then data or device+R
        function void load_byte();
            if (byte_idx == BYTE_DEVICE)
                shift_reg = {dev_addr, 1'b0};
            else if (byte_idx == BYTE_REGISTER)
                shift_reg = req_reg;
            else
                shift_reg = req_read ? {dev_addr, 1'b1} : req_data;
            bit_cnt = 4'd0;
            phase   = PH_WB0;
        endfunction

        // Phase transition at the end of a phase
        function seq_end_t advance(logic s);
            seq_end_t r;
            r = SEQ_RUNNING;
            case (phase)
                PH_ST3: load_byte();
                PH_WB2:
                begin
                    shift_reg = shift_reg << 1;
                    bit_cnt   = bit_cnt + 4'd1;
                    phase     = (bit_cnt >= BITS_PER_BYTE) ? PH_AK0 : PH_WB0;
                end
                PH_AK4: phase = s ? PH_AKF : PH_AK5;
                PH_AK5: phase = (!req_read && byte_idx >= BYTE_PAYLOAD) ? PH_SP0 : PH_GAP;
                PH_AKF: phase = PH_FS0;
                PH_GAP:
                begin
                    if (req_read && byte_idx == BYTE_REGISTER)
                        phase = PH_SP0;
                    else if (req_read && byte_idx >= BYTE_PAYLOAD)
                    begin
                        byte_idx  = BYTE_READING;
                        shift_reg = 8'd0;
                        bit_cnt   = 4'd0;
                        phase     = PH_RB0;
                    end
                    else
                    begin
                        byte_idx = byte_idx + 3'd1;
                        load_byte();
                    end
                end
                PH_SP2:
                begin
                    // a read turns around after the register byte
                    if (req_read && byte_idx == BYTE_REGISTER)
                        phase = PH_WT0;
                    else
                    begin
                        phase = PH_IDLE;
                        r     = SEQ_DONE_OK;
                    end
                end
                PH_FS2:
                begin
                    phase = PH_IDLE;
                    r     = SEQ_DONE_FAIL;
                end
                PH_WT2:
                begin
                    byte_idx = BYTE_PAYLOAD;
                    phase    = PH_ST0;
                end
                PH_RB3:
                begin
                    shift_reg = {shift_reg[6:0], s};
                    bit_cnt   = bit_cnt + 4'd1;
                    phase     = (bit_cnt >= BITS_PER_BYTE) ? PH_NA0 : PH_RB0;
                end
                PH_NA4: phase = PH_SP0;
                default: phase = phase + 6'd1;
            endcase
            return r;
        endfunction

        // One accepted tick: work out the pin state it produces
        function void accept_tick(in_item_t it);
            out_item_t pins;
            seq_end_t  fin;
            int        len;
            logic      rd;
            pins           = '0;
            pins.scl_level = 1'b1;
            pins.sda_level = 1'b1;
            if (phase >= PH_COUNT)
                phase = PH_IDLE;
            if (phase == PH_IDLE)
            begin
                if (it.start_request)
                begin
                    req_read  = it.opcode;
                    req_reg   = it.reg_address;
                    req_data  = it.write_data;
                    byte_idx  = BYTE_DEVICE;
                    bit_cnt   = 4'd0;
                    shift_reg = 8'd0;
                    tick_cnt  = 16'd0;
                    phase     = PH_ST0;
                end
            end
            else
            begin
                len            = (phase_len == 16'd0) ? 1 : int'(phase_len);
                pins.scl_level = CLK_LEVELS[phase];
                pins.sda_level = (phase >= PH_WB0 && phase <= PH_WB2) ? shift_reg[7]
                                                                     : DATA_LEVELS[phase];
                pins.busy_res  = 1'b1;
                if (int'(tick_cnt) + 1 >= len)
                begin
                    rd       = req_read;
                    tick_cnt = 16'd0;
                    fin      = advance(it.sda_sample);
                    if (fin != SEQ_RUNNING)
                    begin
                        pins.done_res  = 1'b1;
                        pins.success   = (fin == SEQ_DONE_OK);
                        pins.read_data = (fin == SEQ_DONE_OK && rd) ? shift_reg : 8'h00;
                    end
                end
                else
                    tick_cnt = tick_cnt + 16'd1;
            end
            expected_pins.push_back(pins);
        endfunction

        function void report(string what, out_item_t want, out_item_t got);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display({"%0t %s: expected scl=%0b sda=%0b busy=%0b done=%0b ok=%0b rd=%02h,",
                          " got scl=%0b sda=%0b busy=%0b done=%0b ok=%0b rd=%02h"},
                         $time, what,
                         want.scl_level, want.sda_level, want.busy_res, want.done_res,
                         want.success, want.read_data,
                         got.scl_level, got.sda_level, got.busy_res, got.done_res,
                         got.success, got.read_data);
        endfunction

        function void check_pins(out_item_t got);
            out_item_t want;
            if (expected_pins.size() == 0)
            begin
                report("pin state with no tick pending", '0, got);
                return;
            end
            want = expected_pins.pop_front();
            if (got.scl_level !== want.scl_level || got.sda_level !== want.sda_level ||
                got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
                got.success !== want.success || got.read_data !== want.read_data)
                report("pin state mismatch", want, got);
        endfunction
    endclass

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    in_item_t                   in_data   = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    out_item_t                  out_data;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;

    sccb_pin_scoreboard sb;
    int                 ticks_sent    = 0;
    bit                 sender_gaps   = 1'b0;
    bit                 sink_stalls   = 1'b0;
    bit                 long_hold_req = 1'b0;

    sccb_register_access_master uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Tick with random content and no start request
    function automatic in_item_t noise_tick();
        in_item_t it;
        it               = IN_BITS'($urandom);
        it.start_request = 1'b0;
        return it;
    endfunction

    // Offer one tick, optionally after an idle burst, and wait for acceptance
    task automatic send_tick(input in_item_t it);
        if (sender_gaps && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        sb.accept_tick(it);
        ticks_sent++;
    endtask

    // Stop offering and wait until every pin state has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_pins.size() != 0) @(posedge clk);
    endtask

    // Write both registers once the result path is empty
    task automatic configure(input logic [6:0] addr, input logic [15:0] ticks);
        logic [15:0] addr_word;
        addr_word = {9'($urandom), addr};
        drain();
        repeat (2) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_DEVICE_ADDRESS;
        cfg_data  <= addr_word;
        do @(posedge clk); while (!cfg_ready);
        sb.write_register(CFG_DEVICE_ADDRESS, addr_word);
        cfg_index <= CFG_PHASE_TICKS;
        cfg_data  <= ticks;
        do @(posedge clk); while (!cfg_ready);
        sb.write_register(CFG_PHASE_TICKS, ticks);
        cfg_valid <= 1'b0;
    endtask

    // Start a transfer if idle, then answer the bus until it ends or the
    // tick limit runs out; nack_mask holds one bit per sent byte
    task automatic run_transfer(input logic op, input logic [7:0] reg_a,
                                input logic [7:0] wdata, input logic [2:0] nack_mask,
                                input logic [7:0] rbyte, input int tick_limit);
        in_item_t it;
        int       n;
        n = 0;
        if (sb.phase == PH_IDLE)
        begin
            it               = IN_BITS'($urandom);
            it.start_request = 1'b1;
            it.opcode        = op;
            it.reg_address   = reg_a;
            it.write_data    = wdata;
            send_tick(it);
        end
        while (sb.phase != PH_IDLE && (tick_limit == 0 || n < tick_limit))
        begin
            // start requests on these ticks land while busy and are ignored
            it = IN_BITS'($urandom);
            if (sb.phase >= PH_AK0 && sb.phase <= PH_AK4)
                it.sda_sample = nack_mask[sb.byte_idx];
            else if (sb.phase >= PH_RB0 && sb.phase <= PH_RB3)
                it.sda_sample = rbyte[3'd7 - sb.bit_cnt[2:0]];
            send_tick(it);
            n++;
        end
    endtask

    // Result side: random ready bursts, plus one long hold-off on request
    initial
    begin : result_sink
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (sink_stalls && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_pins(out_data);
    end

    // Ends the run when no channel moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("sccb_register_access_master verification failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [2:0]  nack;
        logic [15:0] ticks;
        int          xfers;
        sb = new();
        sb.clear();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a write caught in its first phase by length changes
        repeat (3) send_tick(noise_tick());
        run_transfer(OPCODE_WRITE, 8'hFF, 8'h00, 3'b000, 8'h00, 12);
        configure(7'd127, 16'hFFFF);
        run_transfer(OPCODE_WRITE, 8'hFF, 8'h00, 3'b000, 8'h00, 12);
        configure(7'd127, 16'd1);
        run_transfer(OPCODE_WRITE, 8'hFF, 8'h00, 3'b000, 8'h00, 0);

        // Zero length acts as one tick per phase
        configure(7'd0, 16'd0);
        run_transfer(OPCODE_READ, 8'h00, 8'hFF, 3'b000, 8'hA5, 0);
        run_transfer(OPCODE_WRITE, 8'hAA, 8'h55, 3'b100, 8'h00, 0);

        // Missing acknowledge on each byte of a read
        configure(7'h55, 16'd2);
        run_transfer(OPCODE_READ, 8'h5A, 8'h00, 3'b001, 8'h00, 0);
        run_transfer(OPCODE_READ, 8'hC3, 8'h00, 3'b010, 8'h00, 0);
        run_transfer(OPCODE_READ, 8'h3C, 8'h00, 3'b100, 8'hFF, 0);

        // Random transfers, mostly short phases and clean acknowledges
        configure(7'd33, 16'd1);
        sender_gaps   = 1'b1;
        sink_stalls   = 1'b1;
        long_hold_req = 1'b1;
        ticks_sent    = 0;
        xfers         = 0;
        while (ticks_sent < RANDOM_TICKS)
        begin
            if (ticks_sent >= RANDOM_TICKS - CALM_TICKS)
            begin
                sender_gaps = 1'b0;
                sink_stalls = 1'b0;
            end
            repeat ($urandom_range(0, 3)) send_tick(noise_tick());
            nack = ($urandom_range(0, 4) == 0) ? 3'(1 << $urandom_range(0, 2)) : 3'b000;
            run_transfer(1'($urandom), 8'($urandom), 8'($urandom), nack, 8'($urandom), 0);
            xfers++;
            if (xfers == 1)
                drain();
            if (xfers % 2 == 0)
            begin
                case ($urandom_range(0, 7))
                    0:       ticks = 16'd0;
                    1:       ticks = 16'($urandom_range(2, 3));
                    default: ticks = 16'd1;
                endcase
                configure(7'($urandom), ticks);
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (sb.failures == 0)
            $display("sccb_register_access_master verification clean");
        else
            $display("sccb_register_access_master verification failed");
        $finish;
    end

endmodule

// File: sccb_register_access_master.f
rtl/core/sccb_pkg.sv
rtl/core/sccb_register_access_master.sv
tb/testbench.sv
